>>> rtl/core/spn_pkg.sv
// Shared types, S-box and bit permutation for the SPN block cipher.
package spn_pkg;

    localparam int BLK_W = 64;
    localparam int KEY_W = 64;
    localparam int RIDX_W = 5;
    localparam int KEY_ROT = 13;

    // Configuration register indexes
    typedef enum logic
    {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } spn_reg_t;

    // One pipeline beat: block plus the round key it still needs
    typedef struct packed
    {
        logic [BLK_W-1:0] blk;
        logic [KEY_W-1:0] key_hi;
        logic [KEY_W-1:0] key_lo;
    } spn_stage_t;

    localparam logic [3:0] SBOX [16] = '{
        4'h6, 4'h3, 4'hA, 4'h5, 4'hC, 4'h8, 4'h1, 4'hB,
        4'h0, 4'hD, 4'h9, 4'hE, 4'hF, 4'h2, 4'h7, 4'h4
    };

    function automatic logic [3:0] sub_nib(input logic [3:0] n);
        return SBOX[n];
    endfunction

    // bit i moves to bit 16*(i mod 4) + i/4
    function automatic logic [BLK_W-1:0] perm_bits(input logic [BLK_W-1:0] v);
        logic [BLK_W-1:0] r;
        r = '0;
        for (int i = 0; i < BLK_W; i++)
        begin
            r[(i % 4) * 16 + (i / 4)] = v[i];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/spn_cfg.sv
// Key register file written through the plain configuration port.
module spn_cfg
    import spn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [KEY_W-1:0] wr_data,
    output logic [KEY_W-1:0] key_high,
    output logic [KEY_W-1:0] key_low
);

    logic [KEY_W-1:0] key_high_reg;
    logic [KEY_W-1:0] key_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (spn_reg_t'(wr_index))
                REG_KEY_HIGH: key_high_reg <= wr_data;
                REG_KEY_LOW:  key_low_reg  <= wr_data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    assign key_high = key_high_reg;
    assign key_low  = key_low_reg;

endmodule

>>> rtl/core/spn_round.sv
// One registered cipher round: key mix, S-box layer, permutation, key update.
module spn_round
    import spn_pkg::*;
#(
    parameter int ROUND_IDX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  spn_stage_t in_beat,
    output logic       out_valid,
    output spn_stage_t out_beat
);

    localparam logic [RIDX_W-1:0] RIDX = RIDX_W'(ROUND_IDX);

    logic             valid_reg;
    spn_stage_t       beat_reg;
    spn_stage_t       beat_next;
    logic [BLK_W-1:0] mixed;
    logic [BLK_W-1:0] subbed;
    logic [KEY_W-1:0] rot_lo;

    always_comb
    begin
        mixed = in_beat.blk ^ in_beat.key_lo;
        for (int n = 0; n < BLK_W / 4; n++)
        begin
            subbed[n*4 +: 4] = sub_nib(mixed[n*4 +: 4]);
        end
        beat_next.blk = perm_bits(subbed);

        // 128-bit rotate left by 13
        beat_next.key_hi = {in_beat.key_hi[KEY_W-KEY_ROT-1:0],
                            in_beat.key_lo[KEY_W-1:KEY_W-KEY_ROT]};
        rot_lo = {in_beat.key_lo[KEY_W-KEY_ROT-1:0],
                  in_beat.key_hi[KEY_W-1:KEY_W-KEY_ROT]};

        beat_next.key_lo = {rot_lo[KEY_W-1:KEY_W-RIDX_W] ^ RIDX,
                            rot_lo[KEY_W-RIDX_W-1:8],
                            sub_nib(rot_lo[7:4]),
                            sub_nib(rot_lo[3:0])};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

>>> rtl/core/spn_block_cipher_64_128.sv
// Top level: 64-bit block, 128-bit key SPN cipher, one round per pipeline stage.
// Each start beat passes through the round registers in order to the done strobe (ROUNDS is 31 by default).
// Throughput: one block per cycle; busy stays low, the pipeline always accepts.
// Each round is one register stage; the round count sets the stage count.
// Reset (rst_n, async, active low) clears the key registers and every round's valid register.
// The receiver cannot stall: done pulses for one cycle with ciphertext.
module spn_block_cipher_64_128
    import spn_pkg::*;
#(
    parameter int ROUNDS = 31
)
(
    input  logic             clk,
    input  logic             rst_n,
    // command channel
    input  logic             start,
    output logic             busy,
    input  logic [BLK_W-1:0] plaintext,
    // result channel
    output logic             done,
    output logic [BLK_W-1:0] ciphertext,
    // configuration write port
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [KEY_W-1:0] wr_data
);

    logic [KEY_W-1:0] key_high;
    logic [KEY_W-1:0] key_low;

    // stage 0 is the entry beat; stage r+1 is the output of round r
    logic       stg_valid [ROUNDS+1];
    spn_stage_t stg_beat  [ROUNDS+1];

    spn_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .key_high (key_high),
        .key_low  (key_low)
    );

    // No stall anywhere downstream, so every cycle can take a beat.
    assign busy = 1'b0;

    // User must change keys only while idle (not enforced); then sampling them at entry is safe.
    assign stg_valid[0]       = start & ~busy;
    assign stg_beat[0].blk    = plaintext;
    assign stg_beat[0].key_hi = key_high;
    assign stg_beat[0].key_lo = key_low;

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        spn_round #(
            .ROUND_IDX (r)
        ) u_round
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[r]),
            .in_beat   (stg_beat[r]),
            .out_valid (stg_valid[r+1]),
            .out_beat  (stg_beat[r+1])
        );
    end

    // No final whitening: the last round's block is the result.
    assign done       = stg_valid[ROUNDS];
    assign ciphertext = stg_beat[ROUNDS].blk;

    // Every accepted beat comes out as done after passing through every round register.
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##ROUNDS done)
        else $error("accepted beat did not produce done after ROUNDS cycles");

    // No result without a matching accepted beat.
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ROUNDS))
        else $error("done without an accepted start beat");

    // Entry beat carries the key registers as they stood.
    a_entry_key: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid[0] |-> (stg_beat[0].key_lo == key_low && stg_beat[0].key_hi == key_high))
        else $error("entry beat key does not match key registers");

endmodule

>>> tb/spn_block_cipher_64_128_test.sv
// Self-checking testbench for the 64-bit block, 128-bit key SPN cipher pipeline.
module spn_block_cipher_64_128_test;
    import spn_pkg::*;

    localparam int CIPHER_ROUNDS = 31;
    localparam int NUM_PHASES = 8;
    localparam int BLOCKS_PER_PHASE = 179;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_DIRECTED = 20;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // 4-bit substitution used by both the data path and the key schedule
    localparam logic [3:0] NIBBLE_SUB [16] = '{
        4'h6, 4'h3, 4'hA, 4'h5, 4'hC, 4'h8, 4'h1, 4'hB,
        4'h0, 4'hD, 4'h9, 4'hE, 4'hF, 4'h2, 4'h7, 4'h4
    };

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [BLK_W-1:0] plaintext;
    logic             done;
    logic [BLK_W-1:0] ciphertext;
    logic             wr_en;
    spn_reg_t         wr_index;
    logic [KEY_W-1:0] wr_data;

    spn_block_cipher_64_128 #(
        .ROUNDS (CIPHER_ROUNDS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .plaintext  (plaintext),
        .done       (done),
        .ciphertext (ciphertext),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    // One block in flight: its plaintext (for the log) and the ciphertext it must produce
    typedef struct {
        logic [BLK_W-1:0] pt;
        logic [BLK_W-1:0] ct;
    } inflight_block_t;

    // Directed vector: optional rekey (after the pipe drains), then one block
    typedef struct {
        logic             rekey;
        logic [KEY_W-1:0] khi;
        logic [KEY_W-1:0] klo;
        logic [BLK_W-1:0] pt;
    } directed_vec_t;

    inflight_block_t  pending_ct [$];
    logic [KEY_W-1:0] key_hi_shadow;
    logic [KEY_W-1:0] key_lo_shadow;
    int               fail_count;
    int               blocks_sent;
    int               ct_checked;
    int               key_loads;
    int               cycle_count;

    // Substitute the lowest `nibbles` nibbles, the rest pass through
    function automatic logic [63:0] sub_low_nibbles(input logic [63:0] v, input int nibbles);
        logic [63:0] r;
        r = v;
        for (int n = 0; n < nibbles; n++)
        begin
            r[n*4 +: 4] = NIBBLE_SUB[v[n*4 +: 4]];
        end
        return r;
    endfunction

    // Full encryption: round key XOR, S-layer, bit permutation, then key schedule step.
    // No whitening after the last round.
    function automatic logic [63:0] encrypt_block(input logic [63:0] pt,
                                                  input logic [63:0] khi,
                                                  input logic [63:0] klo);
        logic [63:0] st;
        logic [63:0] permuted;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] nhi;
        logic [63:0] nlo;
        logic [4:0]  rnd;
        st = pt;
        hi = khi;
        lo = klo;
        for (int r = 0; r < CIPHER_ROUNDS; r++)
        begin
            st = sub_low_nibbles(st ^ lo, 16);
            permuted = '0;
            for (int i = 0; i < 64; i++)
            begin
                permuted[(i % 4) * 16 + (i / 4)] = st[i];
            end
            st = permuted;
            // 128-bit key rotates left by 13
            nhi = {hi[50:0], lo[63:51]};
            nlo = {lo[50:0], hi[63:51]};
            nlo = sub_low_nibbles(nlo, 2);
            rnd = r[4:0];
            nlo[63:59] = nlo[63:59] ^ rnd;
            hi = nhi;
            lo = nlo;
        end
        return st;
    endfunction

    task automatic log_failure(input string msg);
        if (fail_count < 10)
        begin
            $display("%s", msg);
        end
        fail_count++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: the slowest legal run is far below this
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d blocks still in flight",
                     cycle_count, pending_ct.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Monitor: check the done beat against the oldest in-flight block, then log a new
    // start beat. Keys only change while the pipe is empty, so the shadows are current.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_ct.size() == 0)
                begin
                    log_failure($sformatf("unexpected done beat, ciphertext %016h", ciphertext));
                end
                else
                begin
                    inflight_block_t head;
                    head = pending_ct.pop_front();
                    ct_checked++;
                    if (ciphertext !== head.ct)
                    begin
                        log_failure($sformatf("pt %016h: ciphertext exp %016h got %016h",
                                              head.pt, head.ct, ciphertext));
                    end
                end
            end
            if (start && !busy)
            begin
                pending_ct.push_back('{pt: plaintext,
                                       ct: encrypt_block(plaintext, key_hi_shadow,
                                                         key_lo_shadow)});
            end
        end
    end

    // Send one block; entered and left right after a falling edge.
    // A gap lowers start once, then start rises again at the gap's last falling edge.
    task automatic send_block(input logic [63:0] pt, input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        start     <= 1'b1;
        plaintext <= pt;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        blocks_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every in-flight block has come out
    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_ct.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Load both key halves; only called with the pipe empty
    task automatic load_key(input logic [63:0] khi, input logic [63:0] klo);
        wr_en    <= 1'b1;
        wr_index <= REG_KEY_HIGH;
        wr_data  <= khi;
        @(posedge clk);
        key_hi_shadow = khi;
        @(negedge clk);
        wr_index <= REG_KEY_LOW;
        wr_data  <= klo;
        @(posedge clk);
        key_lo_shadow = klo;
        @(negedge clk);
        wr_en <= 1'b0;
        key_loads++;
    endtask

    initial
    begin
        directed_vec_t directed [NUM_DIRECTED];
        logic [63:0]   khi;
        logic [63:0]   klo;
        logic [63:0]   pt;
        int            idle_pct;

        // First rows run on the reset key (all zero), the rest cover key extremes
        directed = '{
            '{1'b0, 64'h0, 64'h0, 64'h0},
            '{1'b0, 64'h0, 64'h0, ALL_ONES},
            '{1'b0, 64'h0, 64'h0, 64'h8000_0000_0000_0000},
            '{1'b0, 64'h0, 64'h0, 64'h1},
            '{1'b0, 64'h0, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA},
            '{1'b0, 64'h0, 64'h0, 64'h5555_5555_5555_5555},
            '{1'b1, 64'h0, ALL_ONES, 64'h0},
            '{1'b0, 64'h0, ALL_ONES, ALL_ONES},
            '{1'b1, ALL_ONES, 64'h0, 64'h0},
            '{1'b0, ALL_ONES, 64'h0, ALL_ONES},
            '{1'b1, ALL_ONES, ALL_ONES, 64'h0},
            '{1'b0, ALL_ONES, ALL_ONES, ALL_ONES},
            '{1'b0, ALL_ONES, ALL_ONES, 64'h0123_4567_89AB_CDEF},
            '{1'b1, 64'h1, 64'h8000_0000_0000_0000, 64'h0},
            '{1'b0, 64'h1, 64'h8000_0000_0000_0000, 64'hFEDC_BA98_7654_3210},
            '{1'b1, 64'h8000_0000_0000_0000, 64'h1, 64'hF0F0_F0F0_F0F0_F0F0},
            '{1'b0, 64'h8000_0000_0000_0000, 64'h1, 64'h0F0F_0F0F_0F0F_0F0F},
            '{1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h0},
            '{1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hDEAD_BEEF_CAFE_F00D},
            '{1'b1, 64'h0, 64'h0, 64'h0000_0001_0000_0000}
        };

        // Every input known from time zero; reset is held, then released at a falling edge
        rst_n         = 1'b0;
        start         = 1'b0;
        plaintext     = '0;
        wr_en         = 1'b0;
        wr_index      = REG_KEY_HIGH;
        wr_data       = '0;
        key_hi_shadow = '0;
        key_lo_shadow = '0;
        fail_count    = 0;
        blocks_sent   = 0;
        ct_checked    = 0;
        key_loads     = 0;
        cycle_count   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed vectors, back to back except where a rekey drains the pipe
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (directed[i].rekey)
            begin
                drain_pipe();
                load_key(directed[i].khi, directed[i].klo);
            end
            send_block(directed[i].pt, 0);
        end

        // Random phases: new key each phase (extremes now and then), random blocks.
        // Gap density varies per phase; the last phase runs at full rate.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0: begin khi = '0;        klo = '0;        end
                1: begin khi = ALL_ONES;  klo = ALL_ONES;  end
                2: begin khi = {$urandom(), $urandom()}; klo = ALL_ONES; end
                default: begin khi = {$urandom(), $urandom()}; klo = {$urandom(), $urandom()}; end
            endcase
            drain_pipe();
            load_key(khi, klo);
            idle_pct = (ph == NUM_PHASES - 1) ? 0 : $urandom_range(0, 40);
            for (int n = 0; n < BLOCKS_PER_PHASE; n++)
            begin
                // mid-phase: let the pipe run dry before continuing
                if (ph == 2 && n == BLOCKS_PER_PHASE / 2)
                begin
                    drain_pipe();
                end
                case ($urandom_range(0, 15))
                    0: pt = '0;
                    1: pt = ALL_ONES;
                    2: pt = 64'h1 << $urandom_range(0, 63);
                    default: pt = {$urandom(), $urandom()};
                endcase
                send_block(pt, idle_pct);
            end
        end

        drain_pipe();
        // stray done beats after the last block would show up here
        repeat (CIPHER_ROUNDS + 10) @(negedge clk);
        while (pending_ct.size() != 0)
        begin
            inflight_block_t lost;
            lost = pending_ct.pop_front();
            log_failure($sformatf("no ciphertext for pt %016h", lost.pt));
        end

        $display("%0d blocks encrypted across %0d key loads, %0d ciphertexts compared",
                 blocks_sent, key_loads, ct_checked);
        $display("%0d failures in %0d cycles", fail_count, cycle_count);
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
